/* hdl/mme_pkg.sv */
// Package for the matrix multiply engine: transfer payload types,
// configuration register indexes, opcodes and the cell control group.
// No dependencies.
package mme_pkg;

    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_K_W    = 9;
    localparam int CFG_N_W    = 7;
    localparam int CFG_M_W    = 11;

    localparam logic [CFG_IDX_W-1:0] REG_K_DEPTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_N_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_M_ROWS  = 2'd2;

    localparam logic OP_LOAD_B = 1'b0;
    localparam logic OP_A_ELEM = 1'b1;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 48;

    typedef struct packed {
        logic                     op;
        logic signed [ELEM_W-1:0] elem_value;
    } t_in_item;

    typedef struct packed {
        logic [9:0]              row_index;
        logic [5:0]              col_index;
        logic signed [ACC_W-1:0] c_value;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic shift;
        logic add;
        logic drain;
        logic clear;
    } t_cell_ctrl;

endpackage

/* hdl/matrix_multiply_engine_core.sv */
// Matrix multiply engine top level: B store, row sequencer, multiplier and
// the chain of column cells. Depends on mme_pkg and mme_cell.
//
// Use: write k_depth, n_cols, m_rows through the plain write port while idle.
// Items are transferred with start while busy is low. A B load (op 0) is
// written into the B store in the transfer cycle and leaves busy low, so loads
// stream at one per cycle. An A element (op 1) raises busy: the n B entries of
// its row are read one per cycle from the single read port of the store,
// multiplied and shifted into the cell chain, then all active cells add at
// once. The element that completes a row is followed by one result per
// column: o_strobe marks one result per cycle, column 0 first, last on the
// final column, read from the head of the chain as the accumulators shift
// down; the accumulators then clear and busy falls. The receiver cannot
// stall, so results are never held. Reset restores the register defaults,
// clears the accumulators, positions and row counter; the B store keeps no
// reset and must be loaded before use.
module matrix_multiply_engine_core #(
    parameter int MAX_K = 256,
    parameter int MAX_N = 64,
    parameter int MAX_M = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  mme_pkg::t_in_item                   i_in,
    output logic                                o_strobe,
    output mme_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mme_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mme_pkg::*;

    localparam int KW   = $clog2(MAX_K + 1);
    localparam int NW   = $clog2(MAX_N + 1);
    localparam int MW   = $clog2(MAX_M + 1);
    localparam int AKW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW   = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int RW   = (MAX_M > 1) ? $clog2(MAX_M) : 1;
    localparam int DEPTH = MAX_K * MAX_N;
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KNW  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FEED,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state r_state;
    logic [KW-1:0]  r_k;
    logic [NW-1:0]  r_n;
    logic [MW-1:0]  r_m;
    logic [AW-1:0]  r_bpos;
    logic [AKW-1:0] r_kpos;
    logic [RW-1:0]  r_row;
    logic [CW-1:0]  r_j;
    logic [CW-1:0]  r_col;
    logic [AW-1:0]  r_base;
    logic signed [ELEM_W-1:0] r_a;
    logic signed [ELEM_W-1:0] r_rd_data;
    logic signed [PROD_W-1:0] r_prod;
    logic r_rd_valid, r_rd_last, r_prod_valid, r_prod_last, r_add;

    logic signed [ELEM_W-1:0] r_mem [DEPTH];

    logic [CFG_K_W-1:0] cfg_k;
    logic [CFG_N_W-1:0] cfg_n;
    logic [CFG_M_W-1:0] cfg_m;
    logic               accept;
    logic               b_we;
    logic [KNW-1:0]     kn;
    logic [AW-1:0]      bpos_eff;
    logic [KNW-1:0]     bpos_inc;
    logic               rd_en;
    logic               rd_last;
    logic [AW-1:0]      rd_addr;
    logic [KW:0]        kpos_inc;
    logic [RW:0]        row_inc;
    logic [CW-1:0]      n_last;
    logic signed [PROD_W-1:0] mul;
    t_cell_ctrl         ctrl;

    logic signed [PROD_W-1:0] prod_link [MAX_N+1];
    logic signed [ACC_W-1:0]  acc_link  [MAX_N+1];

    assign cfg_k = i_cfg_data[CFG_K_W-1:0];
    assign cfg_n = i_cfg_data[CFG_N_W-1:0];
    assign cfg_m = i_cfg_data[CFG_M_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= KW'(MAX_K);
            r_n <= NW'(MAX_N);
            r_m <= MW'(MAX_M);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_K_DEPTH: begin
                    r_k <= (cfg_k == '0) ? KW'(1) :
                           (32'(cfg_k) > MAX_K) ? KW'(MAX_K) : KW'(cfg_k);
                end
                REG_N_COLS: begin
                    r_n <= (cfg_n == '0) ? NW'(1) :
                           (32'(cfg_n) > MAX_N) ? NW'(MAX_N) : NW'(cfg_n);
                end
                REG_M_ROWS: begin
                    r_m <= (cfg_m == '0) ? MW'(1) :
                           (32'(cfg_m) > MAX_M) ? MW'(MAX_M) : MW'(cfg_m);
                end
                default: begin
                end
            endcase
        end
    end

    assign accept   = start && !busy;
    assign b_we     = accept && (i_in.op == OP_LOAD_B);
    assign kn       = KNW'(r_k) * KNW'(r_n);
    assign bpos_eff = (KNW'(r_bpos) >= kn) ? '0 : r_bpos;
    assign bpos_inc = KNW'(bpos_eff) + KNW'(1);
    assign n_last   = CW'(r_n - NW'(1));
    assign kpos_inc = (KW+1)'(r_kpos) + (KW+1)'(1);
    assign row_inc  = (RW+1)'(r_row) + (RW+1)'(1);

    assign rd_en   = (r_state == S_FEED);
    assign rd_last = (r_j == '0);
    assign rd_addr = r_base + AW'(r_j);

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_mem[bpos_eff] <= i_in.elem_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos <= '0;
        end else if (b_we) begin
            r_bpos <= (bpos_inc >= kn) ? '0 : AW'(bpos_inc);
        end
    end

    assign mul = r_a * r_rd_data;

    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_prod <= mul;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid   <= 1'b0;
            r_rd_last    <= 1'b0;
            r_prod_valid <= 1'b0;
            r_prod_last  <= 1'b0;
            r_add        <= 1'b0;
        end else begin
            r_rd_valid   <= rd_en;
            r_rd_last    <= rd_en && rd_last;
            r_prod_valid <= r_rd_valid;
            r_prod_last  <= r_rd_last;
            r_add        <= r_prod_valid && r_prod_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kpos  <= '0;
            r_row   <= '0;
            r_j     <= '0;
            r_col   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_in.op == OP_A_ELEM)) begin
                        r_j     <= n_last;
                        r_state <= S_FEED;
                    end
                end
                S_FEED: begin
                    r_j <= r_j - CW'(1);
                    if (rd_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_add) begin
                        if (kpos_inc >= (KW+1)'(r_k)) begin
                            r_col   <= '0;
                            r_state <= S_OUT;
                            if (MW'(r_row) >= r_m) begin
                                r_row <= '0;
                            end
                        end else begin
                            r_kpos  <= AKW'(kpos_inc);
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    r_col <= r_col + CW'(1);
                    if (r_col == n_last) begin
                        r_kpos  <= '0;
                        r_row   <= (32'(row_inc) >= 32'(r_m)) ? '0 : RW'(row_inc);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_in.op == OP_A_ELEM)) begin
            r_a    <= i_in.elem_value;
            r_base <= AW'(AW'(r_kpos) * AW'(r_n));
        end
    end

    always_comb begin
        ctrl.shift = r_prod_valid;
        ctrl.add   = r_add;
        ctrl.drain = (r_state == S_OUT) && (r_col != n_last);
        ctrl.clear = (r_state == S_OUT) && (r_col == n_last);
    end

    assign prod_link[0]     = r_prod;
    assign acc_link[MAX_N]  = '0;

    for (genvar g = 0; g < MAX_N; g++) begin : g_cell
        mme_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_active (32'(g) < 32'(r_n)),
            .i_prod   (prod_link[g]),
            .o_prod   (prod_link[g+1]),
            .i_acc    (acc_link[g+1]),
            .o_acc    (acc_link[g])
        );
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_OUT);

    always_comb begin
        o_result.row_index = 10'(r_row);
        o_result.col_index = 6'(r_col);
        o_result.c_value   = acc_link[0];
        o_result.last      = (r_col == n_last);
    end

`ifndef NO_ASSERTIONS
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while not busy");

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |=> (!o_strobe && !busy))
        else $error("results continue after last");

    a_add_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_add |-> (r_state == S_DRAIN))
        else $error("cell add outside drain");

    a_a_starts_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_in.op == OP_A_ELEM)) |=> (r_state == S_FEED))
        else $error("A element transfer did not start feed");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_we |=> !busy)
        else $error("B load raised busy");
`endif

endmodule

/* hdl/mme_cell.sv */
// One column cell: a product stage of the feed chain and one column accumulator.
// Depends on mme_pkg.
module mme_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mme_pkg::t_cell_ctrl                  i_ctrl,
    input  logic                                 i_active,
    input  logic signed [mme_pkg::PROD_W-1:0]    i_prod,
    output logic signed [mme_pkg::PROD_W-1:0]    o_prod,
    input  logic signed [mme_pkg::ACC_W-1:0]     i_acc,
    output logic signed [mme_pkg::ACC_W-1:0]     o_acc
);
    import mme_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_prod <= i_prod;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_acc = '0;
        end else if (i_ctrl.drain) begin
            n_acc = i_acc;
        end else if (i_ctrl.add && i_active) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule
